// ===== rtl/cdcq_pkg.sv =====
package cdcq_pkg;

  localparam int unsigned HANDLER_W = 32;
  localparam int unsigned ARG_W     = 32;
  localparam int unsigned OCC_W     = 7;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_COALESCED = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // One queue slot as it moves along the row of cells.
  typedef struct packed {
    logic                 valid;
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     argument;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                 shift;
    logic                 append;
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     argument;
  } cell_ctrl_t;

endpackage

// ===== rtl/cdcq_cmd_if.sv =====
interface cdcq_cmd_if;
  import cdcq_pkg::*;

  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  logic [HANDLER_W-1:0] handler_id;
  logic [ARG_W-1:0]     call_argument;

  modport source (output valid, opcode, handler_id, call_argument, input ready);
  modport sink   (input valid, opcode, handler_id, call_argument, output ready);
endinterface

// ===== rtl/cdcq_res_if.sv =====
interface cdcq_res_if;
  import cdcq_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [HANDLER_W-1:0] out_handler;
  logic [ARG_W-1:0]     out_argument;
  logic                 raise_request;
  logic [OCC_W-1:0]     occupancy;

  modport source (output valid, status, out_handler, out_argument, raise_request, occupancy,
                  input ready);
  modport sink   (input valid, status, out_handler, out_argument, raise_request, occupancy,
                  output ready);
endinterface

// ===== rtl/coalescing_deferred_call_queue_core.sv =====
// Deduplicating FIFO of deferred calls held in a row of QUEUE_DEPTH cells, oldest entry
// in the first cell. Each word passes through its steps in turn, and the next word is not
// accepted until the last has finished them: the step in which it is accepted and latched,
// one in which every cell compares its entry with the request and registers a hit, and
// one in which the hits are combined and the queue is updated. A dequeue shifts every
// cell toward the head at once. The next word can be accepted in the cycle after the
// result is loaded into the output register, even if that result has not yet been
// taken; the update step waits only while the output register still holds an
// untaken result.
module coalescing_deferred_call_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  cdcq_cmd_if.sink     cmd,
  cdcq_res_if.source   res
);
  import cdcq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  opcode_t              op;
  logic [HANDLER_W-1:0] req_handler;
  logic [ARG_W-1:0]     req_argument;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  entry_t                 cells [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match;
  cell_ctrl_t             ctrl;

  logic    fire;
  logic    hit;
  logic    is_full;
  logic    is_empty;
  status_t status_next;
  logic    raise_next;

  assign cmd.ready = (state == S_IDLE);
  assign fire      = (state == S_DECIDE) && (!res.valid || res.ready);
  assign hit       = |match;
  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count == '0);

  always_comb begin
    status_next = ST_EMPTY;
    raise_next  = 1'b0;
    count_next  = count;
    ctrl.shift    = 1'b0;
    ctrl.append   = 1'b0;
    ctrl.handler  = req_handler;
    ctrl.argument = req_argument;
    if (op == OP_ENQUEUE) begin
      if (hit) begin
        status_next = ST_COALESCED;
      end else if (is_full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_QUEUED;
        raise_next  = is_empty;
        count_next  = count + 1'b1;
        ctrl.append = fire;
      end
    end else if (!is_empty) begin
      status_next = ST_DEQUEUED;
      count_next  = count - 1'b1;
      ctrl.shift  = fire;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_valid;
    entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cells[i-1].valid;
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = cells[i+1];
    end
    cdcq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (prev_valid),
      .next_entry (next_entry),
      .entry      (cells[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (cmd.valid) state_next = S_MATCH;
      S_MATCH:  state_next = S_DECIDE;
      S_DECIDE: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op           <= cmd.opcode;
      req_handler  <= cmd.handler_id;
      req_argument <= cmd.call_argument;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.status        <= status_next;
      res.raise_request <= raise_next;
      res.occupancy     <= OCC_W'(count_next);
      if (ctrl.shift) begin
        res.out_handler  <= cells[0].handler;
        res.out_argument <= cells[0].argument;
      end else begin
        res.out_handler  <= '0;
        res.out_argument <= '0;
      end
    end
  end

endmodule

// ===== rtl/cdcq_cell.sv =====
module cdcq_cell (
  input  logic                clk,
  input  logic                rst,
  input  cdcq_pkg::cell_ctrl_t ctrl,
  input  logic                prev_valid,
  input  cdcq_pkg::entry_t    next_entry,
  output cdcq_pkg::entry_t    entry,
  output logic                match
);
  import cdcq_pkg::*;

  logic take_append;

  // Slots fill from the head end, so the first empty cell behind a full one takes the append.
  assign take_append = ctrl.append && !entry.valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctrl.shift) begin
      entry.valid <= next_entry.valid;
    end else if (take_append) begin
      entry.valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry.handler  <= next_entry.handler;
      entry.argument <= next_entry.argument;
    end else if (take_append) begin
      entry.handler  <= ctrl.handler;
      entry.argument <= ctrl.argument;
    end
  end

  always_ff @(posedge clk) begin
    match <= entry.valid && (entry.handler == ctrl.handler) &&
             (entry.argument == ctrl.argument);
  end

endmodule

// ===== rtl/cdcq_checker.sv =====
module cdcq_checker #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       res_valid,
  input logic                       res_ready,
  input cdcq_pkg::status_t          status,
  input logic [cdcq_pkg::HANDLER_W-1:0] out_handler,
  input logic [cdcq_pkg::ARG_W-1:0]     out_argument,
  input logic                       raise_request,
  input logic [cdcq_pkg::OCC_W-1:0] occupancy
);
  import cdcq_pkg::*;

  // A held result must not change under the consumer.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(occupancy))
    else $error("result word changed while stalled");

  // Only a dequeue carries a payload.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_DEQUEUED |-> out_handler == '0 && out_argument == '0)
    else $error("non-dequeue result carries payload");

  // The raise flag marks the first entry into an empty queue.
  a_raise: assert property (@(posedge clk) disable iff (rst)
    res_valid && raise_request |-> status == ST_QUEUED && occupancy == OCC_W'(1))
    else $error("raise flag without first enqueue");

  // Empty reports only on an empty queue, full reports only on a full one.
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status != ST_EMPTY || occupancy == '0) &&
                  (status != ST_FULL || occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("status disagrees with occupancy");

endmodule

bind coalescing_deferred_call_queue_core cdcq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_cdcq_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .status        (res.status),
  .out_handler   (res.out_handler),
  .out_argument  (res.out_argument),
  .raise_request (res.raise_request),
  .occupancy     (res.occupancy)
);

// ===== sim/coalescing_deferred_call_queue_core_test.sv =====
module coalescing_deferred_call_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdcq_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned WORD_TARGET = 1300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    opcode_t              op;
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     argument;
  } call_word_t;

  typedef struct {
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     argument;
  } deferred_call_t;

  typedef struct {
    status_t              status;
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     argument;
    logic                 raise;
    logic [OCC_W-1:0]     occupancy;
  } queue_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdcq_cmd_if cmd ();
  cdcq_res_if res ();

  coalescing_deferred_call_queue_core #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  call_word_t     pending_words[$];
  call_word_t     offered_word;
  deferred_call_t model_queue[$];
  queue_outcome_t expected_outcomes[$];
  queue_outcome_t oldest_outcome;
  int unsigned    accepted_words = 0;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling pattern changes every few dozen accepted words so that gaps land on
  // every stage of the pipeline.
  function automatic int unsigned idle_phase();
    return (accepted_words / 89) % 4;
  endfunction

  function automatic bit sender_idles();
    case (idle_phase())
      1: return $urandom_range(99) < 88;
      3: return $urandom_range(99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_phase())
      2: return $urandom_range(99) < 88;
      3: return $urandom_range(99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string what);
    error_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic queue_outcome_t apply_call(input call_word_t w);
    queue_outcome_t o;
    bit             hit;
    o = '{ST_QUEUED, '0, '0, 1'b0, '0};
    hit = 1'b0;
    if (w.op == OP_ENQUEUE) begin
      foreach (model_queue[i]) begin
        if (model_queue[i].handler == w.handler && model_queue[i].argument == w.argument)
          hit = 1'b1;
      end
      if (hit) begin
        o.status = ST_COALESCED;
      end else if (model_queue.size() >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        o.raise = (model_queue.size() == 0);
        model_queue.push_back('{w.handler, w.argument});
        o.status = ST_QUEUED;
      end
    end else begin
      if (model_queue.size() == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.handler  = model_queue[0].handler;
        o.argument = model_queue[0].argument;
        void'(model_queue.pop_front());
        o.status = ST_DEQUEUED;
      end
    end
    o.occupancy = OCC_W'(model_queue.size());
    return o;
  endfunction

  task automatic add_enqueue(input logic [HANDLER_W-1:0] h, input logic [ARG_W-1:0] a);
    pending_words.push_back('{OP_ENQUEUE, h, a});
  endtask

  // Dequeue operands are don't-care, so they carry random bits.
  task automatic add_dequeue();
    pending_words.push_back('{OP_DEQUEUE, $urandom, $urandom});
  endtask

  task automatic add_drain(input int unsigned n);
    repeat (n) add_dequeue();
  endtask

  // Empty the queue, fill it with fresh calls, then push past full with both new
  // and duplicate calls, then dequeue between one and six entries.
  task automatic add_fill_episode();
    deferred_call_t stored[$];
    deferred_call_t c;
    add_drain(DEPTH + 1);
    repeat (DEPTH) begin
      c = '{$urandom, $urandom};
      stored.push_back(c);
      add_enqueue(c.handler, c.argument);
    end
    repeat (2) add_enqueue($urandom, $urandom);
    repeat (3) begin
      c = stored[$urandom_range(DEPTH - 1)];
      add_enqueue(c.handler, c.argument);
    end
    repeat ($urandom_range(6, 1)) add_dequeue();
  endtask

  // A small pool of calls around a random base makes coalescing frequent.
  task automatic add_pool_episode();
    logic [HANDLER_W-1:0] hbase;
    logic [ARG_W-1:0]     abase;
    hbase = $urandom;
    abase = $urandom;
    repeat (40) begin
      if ($urandom_range(99) < 60)
        add_enqueue(hbase ^ HANDLER_W'($urandom_range(3)), abase ^ ARG_W'($urandom_range(3)));
      else
        add_dequeue();
    end
  endtask

  task automatic add_noise();
    repeat (10) begin
      if ($urandom_range(1) == 0)
        add_enqueue($urandom, $urandom);
      else
        add_dequeue();
    end
  endtask

  task automatic build_stimulus();
    int unsigned pick;
    add_dequeue();
    add_enqueue('0, '0);
    add_enqueue('0, '0);
    add_enqueue('1, '1);
    add_enqueue('0, '1);
    add_enqueue('1, '0);
    add_enqueue('1, '1);
    add_dequeue();
    add_enqueue('0, '0);
    add_drain(5);
    add_enqueue(32'd1, 32'd2);
    add_dequeue();
    while (pending_words.size() < WORD_TARGET) begin
      pick = $urandom_range(9);
      if (pick < 2)      add_drain($urandom_range(DEPTH + 2, 8));
      else if (pick < 4) add_fill_episode();
      else if (pick < 8) add_pool_episode();
      else               add_noise();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        expected_outcomes.push_back(apply_call(offered_word));
        accepted_words++;
      end
      if (!cmd.valid || cmd.ready) begin
        if (pending_words.size() > 0 && !sender_idles()) begin
          offered_word = pending_words.pop_front();
          cmd.valid         <= 1'b1;
          cmd.opcode        <= offered_word.op;
          cmd.handler_id    <= offered_word.handler;
          cmd.call_argument <= offered_word.argument;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_outcomes.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          oldest_outcome = expected_outcomes.pop_front();
          if (res.status !== oldest_outcome.status)
            report($sformatf("status %0d, expected %0d", res.status, oldest_outcome.status));
          if (res.out_handler !== oldest_outcome.handler)
            report($sformatf("out_handler %h, expected %h", res.out_handler,
                             oldest_outcome.handler));
          if (res.out_argument !== oldest_outcome.argument)
            report($sformatf("out_argument %h, expected %h", res.out_argument,
                             oldest_outcome.argument));
          if (res.raise_request !== oldest_outcome.raise)
            report($sformatf("raise_request %b, expected %b", res.raise_request,
                             oldest_outcome.raise));
          if (res.occupancy !== oldest_outcome.occupancy)
            report($sformatf("occupancy %0d, expected %0d", res.occupancy,
                             oldest_outcome.occupancy));
        end
      end
      res.ready <= !receiver_stalls();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cmd.valid         = 1'b0;
    cmd.opcode        = OP_ENQUEUE;
    cmd.handler_id    = '0;
    cmd.call_argument = '0;
    res.ready         = 1'b0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !cmd.valid);
    wait (expected_outcomes.size() == 0);
    repeat (10) @(posedge clk);
    if (expected_outcomes.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_outcomes.size()));
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cdcq_pkg.sv
rtl/cdcq_cmd_if.sv
rtl/cdcq_res_if.sv
rtl/cdcq_cell.sv
rtl/coalescing_deferred_call_queue_core.sv
rtl/cdcq_checker.sv
sim/coalescing_deferred_call_queue_core_test.sv
